// ----- design/soc_pkg.sv -----
package soc_pkg;

  // search limits
  localparam int unsigned MAX_PATTERN = 16;
  localparam longint unsigned MAX_TEXT = 64'd65536;

  // pattern registers hold a fixed 16 bytes, higher pattern bytes read as zero
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PIDX_W = $clog2(PAT_BYTES);

  // field widths
  localparam int unsigned LEN_W = 5;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned POS_W = $clog2(MAX_TEXT) + 1;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  // one classified text word
  typedef struct packed {
    logic             skip;   // beyond text limit, not searched
    logic             hit;    // a match ends at this word
    logic [IDX_W-1:0] start;  // start index of that match
    logic             last;   // final word of the text
  } soc_entry_t;

endpackage

// ----- design/soc_front.sv -----
module soc_front import soc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic [7:0]       in_text_byte,
  input  logic             in_last_byte,
  input  logic             q_full,
  output logic             q_push,
  output soc_entry_t       q_entry
);

  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_high_r;
  logic [LEN_W-1:0] pat_len_r;

  logic [7:0]       win_r [MAX_PATTERN-1];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  logic [LEN_W-1:0] len_sat;
  logic [7:0]       pat_bytes [PAT_BYTES];
  logic [7:0]       seq [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] byte_ok;
  logic             skip;
  logic             hit;
  logic [POS_W-1:0] start_full;

  assign len_sat = (pat_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_r;

  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      pat_bytes[j] = (j < 8) ? pat_low_r[8*(j%8) +: 8] : pat_high_r[8*(j%8) +: 8];
    end
    seq[0] = in_text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      seq[k] = win_r[k-1];
    end
  end

  // pattern byte len-1-k lines up with the word k places back
  always_comb begin
    logic [LEN_W-1:0] idx;
    logic [7:0]       pbyte;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = len_sat - LEN_W'(k) - LEN_W'(1);
      pbyte = (idx < LEN_W'(PAT_BYTES)) ? pat_bytes[idx[PIDX_W-1:0]] : 8'd0;
      byte_ok[k] = (LEN_W'(k) >= len_sat) || (pbyte == seq[k]);
    end
  end

  assign skip = (pos_r >= POS_W'(MAX_TEXT));
  assign hit = (len_sat == '0) ||
               (((pos_r + POS_W'(1)) >= POS_W'(len_sat)) && (&byte_ok));
  assign start_full = (len_sat == '0) ? pos_r : (pos_r + POS_W'(1) - POS_W'(len_sat));

  assign q_push = in_valid && !q_full;
  assign q_entry = '{skip: skip, hit: hit && !skip,
                     start: start_full[IDX_W-1:0], last: in_last_byte};

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_last_byte) begin
        pos_nxt = '0;
      end else if (!skip) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      pos_r      <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PATTERN_LOW:    pat_low_r  <= cfg_data;
          REG_PATTERN_HIGH:   pat_high_r <= cfg_data;
          REG_PATTERN_LENGTH: pat_len_r  <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // window slots older than the text are never compared, so no reset
  always_ff @(posedge clk) begin
    if (q_push && !skip) begin
      win_r[0] <= in_text_byte;
      for (int k = 1; k < MAX_PATTERN - 1; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_TEXT)) else $error("position past text limit");

endmodule

// ----- design/soc_queue.sv -----
module soc_queue import soc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  soc_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output soc_entry_t head
);

  soc_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");

endmodule

// ----- design/soc_back.sv -----
module soc_back import soc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  soc_entry_t       q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [IDX_W-1:0] out_first_pos,
  output logic [CNT_W-1:0] out_match_count,
  output logic             out_overflow
);

  logic             seen_r, seen_nxt;
  logic             tl_r, tl_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             ov_r, ov_nxt;
  logic             found_r;
  logic [IDX_W-1:0] oidx_r;
  logic [CNT_W-1:0] ocnt_r;
  logic             oflow_r;
  logic             load;

  // a last word waits only while the output register is held
  assign q_pop = !q_empty && (!q_head.last || !ov_r || !out_stall);
  assign load  = q_pop && q_head.last;

  always_comb begin
    seen_nxt  = seen_r;
    tl_nxt    = tl_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    if (q_pop) begin
      if (q_head.skip) begin
        tl_nxt = 1'b1;
      end else if (q_head.hit) begin
        if (!seen_r) begin
          first_nxt = q_head.start;
        end
        seen_nxt = 1'b1;
        if (cnt_r < CNT_W'(MAX_TEXT)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  assign ov_nxt = (ov_r && out_stall) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      tl_r    <= 1'b0;
      first_r <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (load) begin
        seen_r  <= 1'b0;
        tl_r    <= 1'b0;
        first_r <= '0;
        cnt_r   <= '0;
      end else begin
        seen_r  <= seen_nxt;
        tl_r    <= tl_nxt;
        first_r <= first_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found_r <= seen_nxt;
      oidx_r  <= seen_nxt ? first_nxt : '0;
      ocnt_r  <= cnt_nxt;
      oflow_r <= tl_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_found       = found_r;
  assign out_first_pos   = oidx_r;
  assign out_match_count = ocnt_r;
  assign out_overflow    = oflow_r;

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TEXT)) else $error("match count past limit");

  a_cnt_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (cnt_r == '0) && (first_r == '0)) else $error("count without a match");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !found_r |-> (oidx_r == '0) && (ocnt_r == '0))
    else $error("result without match carries data");

endmodule

// ----- design/substring_occurrence_counter.sv -----
// a last word passes through the queue and then the output register before its result shows on out_
// throughput: one text word per cycle while the queue is not full, set by the combinational parallel window compare
// the 4-entry queue lets the front keep taking words while a finished result is stalled
// configuration writes are never stalled, cfg_ready is always high
// reset: synchronous active-low rst_n clears pattern registers, position, counters,
// queue and output valid; no clearing pass is needed
module substring_occurrence_counter import soc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // text word channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_text_byte,
  input  logic             in_last_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [IDX_W-1:0] out_first_pos,
  output logic [CNT_W-1:0] out_match_count,
  output logic             out_overflow
);

  logic       q_push;
  soc_entry_t q_entry;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  soc_entry_t q_head;

  // registers are always writable
  assign cfg_ready = 1'b1;
  // front stalls only on a full queue
  assign in_stall = q_full;

  // front: holds pattern and byte window, classifies each word
  soc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_reg_t'(cfg_index)),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // short queue decouples front and back
  soc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: counts matches, records first start, emits the result on the last word
  soc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_first_pos   (out_first_pos),
    .out_match_count (out_match_count),
    .out_overflow    (out_overflow)
  );

endmodule

// ----- tb/sv/substring_search_checker.sv -----
`timescale 1ns / 100ps
module substring_search_checker import soc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_text_byte,
  input  logic             in_last_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_found,
  input  logic [IDX_W-1:0] out_first_pos,
  input  logic [CNT_W-1:0] out_match_count,
  input  logic             out_overflow,
  output int               fail_count,
  output int               waiting_results
);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_pos;
    logic [CNT_W-1:0] match_count;
    logic             overflow;
  } search_report_t;

  search_report_t   expected_reports[$];
  search_report_t   oldest;

  logic [CFG_W-1:0] pat_lo;
  logic [CFG_W-1:0] pat_hi;
  logic [LEN_W-1:0] pat_len;

  // previous text words, newest at index 0
  logic [7:0]       history [MAX_PATTERN-1];
  int               text_pos;
  int               hit_total;
  logic [IDX_W-1:0] first_hit;
  logic             any_hit;
  logic             past_limit;

  function automatic logic [7:0] pattern_char(int k);
    if (k < 8) return pat_lo[8*k +: 8];
    if (k < 16) return pat_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  task automatic restart_text();
    for (int i = 0; i < MAX_PATTERN - 1; i++) history[i] = 8'h00;
    text_pos   = 0;
    hit_total  = 0;
    first_hit  = '0;
    any_hit    = 1'b0;
    past_limit = 1'b0;
  endtask

  task automatic scan_text_byte(logic [7:0] ch, logic ends);
    int             len;
    int             start;
    logic           hit;
    search_report_t rep;
    len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    if (text_pos >= int'(MAX_TEXT)) begin
      past_limit = 1'b1;
    end else begin
      hit = 1'b1;
      if (len != 0) begin
        if (text_pos + 1 < len || pattern_char(len - 1) != ch) hit = 1'b0;
        for (int k = 1; k < len; k++)
          if (pattern_char(len - 1 - k) != history[k-1]) hit = 1'b0;
      end
      if (hit) begin
        start = (len == 0) ? text_pos : text_pos + 1 - len;
        if (!any_hit) first_hit = start[IDX_W-1:0];
        any_hit = 1'b1;
        if (hit_total < int'(MAX_TEXT)) hit_total++;
      end
      for (int k = MAX_PATTERN - 2; k > 0; k--) history[k] = history[k-1];
      history[0] = ch;
      text_pos++;
    end
    if (ends) begin
      rep.found       = any_hit;
      rep.first_pos   = any_hit ? first_hit : '0;
      rep.match_count = hit_total[CNT_W-1:0];
      rep.overflow    = past_limit;
      expected_reports.push_back(rep);
      restart_text();
    end
  endtask

  task automatic report_mismatch(string field, longint unsigned exp_v, longint unsigned act_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = '0;
      restart_text();
      expected_reports.delete();
    end else begin
      // a word accepted at the same edge as a write still sees the old pattern
      if (in_valid && !in_stall) scan_text_byte(in_text_byte, in_last_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LOW:    pat_lo  = cfg_data;
          REG_PATTERN_HIGH:   pat_hi  = cfg_data;
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          $display({"%0t: unexpected result, expected none, ",
                    "got found %0d first %0d count %0d ovf %0d"},
                   $time, out_found, out_first_pos, out_match_count, out_overflow);
        end else begin
          oldest = expected_reports.pop_front();
          if (out_found !== oldest.found)
            report_mismatch("found", oldest.found, out_found);
          if (out_first_pos !== oldest.first_pos)
            report_mismatch("first_pos", oldest.first_pos, out_first_pos);
          if (out_match_count !== oldest.match_count)
            report_mismatch("match_count", oldest.match_count, out_match_count);
          if (out_overflow !== oldest.overflow)
            report_mismatch("overflow", oldest.overflow, out_overflow);
        end
      end
    end
    waiting_results <= expected_reports.size();
  end

endmodule

// ----- tb/sv/tb_substring_occurrence_counter.sv -----
`timescale 1ns / 100ps
module tb_substring_occurrence_counter;
  import soc_pkg::*;

  // index past the last register, writes to it must be ignored
  localparam logic [1:0] REG_OUT_OF_RANGE = 2'd3;

  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_WORDS    = 145;
  localparam int PRESSURE_PHASE = 8;
  localparam int HOLD_CYCLES    = 80;
  // settle time after every expected result is back, for margin
  localparam int SETTLE_CYCLES  = 4;
  // pattern length register per random phase, includes zero, full and oversized
  localparam int PHASE_LENGTHS [RANDOM_PHASES] = '{0, 1, 2, 3, 4, 7, 8, 9, 15, 16, 17, 31};

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index     = '0;
  logic [CFG_W-1:0] cfg_data      = '0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [7:0]       in_text_byte  = '0;
  logic             in_last_byte  = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic             out_found;
  logic [IDX_W-1:0] out_first_pos;
  logic [CNT_W-1:0] out_match_count;
  logic             out_overflow;

  int fail_count;
  int waiting_results;

  // idle rates in percent, changed per phase
  int send_idle_pct = 35;
  int recv_idle_pct = 55;
  // each increment asks the result side for one long hold-off
  int hold_requests = 0;

  // current pattern as seen by the text generator
  logic [7:0] pat_chars [MAX_PATTERN];
  int         pat_used;
  logic [7:0] sym_a;
  logic [7:0] sym_b;
  logic [7:0] text_buf[$];

  substring_occurrence_counter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_first_pos   (out_first_pos),
    .out_match_count (out_match_count),
    .out_overflow    (out_overflow)
  );

  substring_search_checker search_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_first_pos   (out_first_pos),
    .out_match_count (out_match_count),
    .out_overflow    (out_overflow),
    .fail_count      (fail_count),
    .waiting_results (waiting_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // one register write, cfg_valid stays high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full pattern setup, with a stray write to the unused index in between
  task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                           input logic [LEN_W-1:0] len);
    logic [CFG_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_OUT_OF_RANGE, junk);
    // upper bits of the length word carry noise, only the low bits count
    write_reg(REG_PATTERN_LENGTH, {junk[CFG_W-1:LEN_W], len});
    cfg_valid <= 1'b0;
  endtask

  // offer one word after an optional idle gap, return once it is taken
  task automatic send_word(input logic [7:0] ch, input logic ends);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= ch;
    in_last_byte <= ends;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
  endtask

  // wait until every result is back and the block has settled
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // text mixing whole pattern copies, broken prefixes, pattern-like symbols and noise
  task automatic fill_text(input int len);
    int r;
    int n;
    text_buf.delete();
    while (text_buf.size() < len) begin
      r = $urandom_range(99);
      if (r < 30) begin
        n = (r < 20) ? pat_used : $urandom_range(pat_used);
        for (int k = 0; k < n; k++) text_buf.push_back(pat_chars[k]);
      end else if (r < 75) begin
        text_buf.push_back($urandom_range(1) ? sym_a : sym_b);
      end else begin
        text_buf.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int               len_reg;
    int               sent;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: empty pattern hits every word
    text_buf = '{8'h00, 8'hFF};
    send_text();
    finish_phase();

    // "aba": overlapping hits, a text shorter than the pattern, a late first hit
    configure(64'h0000_0000_0061_6261, 64'h0, 5'd3);
    text_buf = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
    send_text();
    text_buf = '{8'h61, 8'h62};
    send_text();
    text_buf = '{8'h78, 8'h61, 8'h62, 8'h61};
    send_text();
    finish_phase();

    // full-length pattern spanning both pattern registers
    configure({CFG_W{1'b1}}, {CFG_W{1'b0}}, 5'd16);
    text_buf.delete();
    for (int i = 0; i < 16; i++) text_buf.push_back(i < 8 ? 8'hFF : 8'h00);
    send_text();
    finish_phase();

    // random phases, idle pattern changes every four phases
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle_pct = (ph < 4) ? 35 : (ph < 8) ? 55 : 0;
      recv_idle_pct = (ph < 4) ? 55 : (ph < 8) ? 35 : 0;
      sym_a   = 8'($urandom_range(255));
      sym_b   = 8'($urandom_range(255));
      len_reg = PHASE_LENGTHS[ph];
      pat_used = (len_reg > MAX_PATTERN) ? MAX_PATTERN : len_reg;
      // two-symbol patterns make overlaps likely, one phase uses arbitrary bytes
      for (int k = 0; k < MAX_PATTERN; k++)
        pat_chars[k] = (k < pat_used && ph != 5) ? ($urandom_range(1) ? sym_a : sym_b)
                                                 : 8'($urandom_range(255));
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = pat_chars[k];
        hi[8*k +: 8] = pat_chars[k+8];
      end
      configure(lo, hi, len_reg[LEN_W-1:0]);
      // long hold on results while short texts keep coming, fills the block
      if (ph == PRESSURE_PHASE) hold_requests <= hold_requests + 1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if (ph == PRESSURE_PHASE || $urandom_range(9) == 0)
          fill_text($urandom_range(1, 3));
        else
          fill_text($urandom_range(4, 40));
        send_text();
        sent += text_buf.size();
      end
      finish_phase();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/soc_pkg.sv
design/soc_front.sv
design/soc_queue.sv
design/soc_back.sv
design/substring_occurrence_counter.sv
tb/sv/substring_search_checker.sv
tb/sv/tb_substring_occurrence_counter.sv
